// ===== sv/sparse_matrix_fast_transpose_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SPARSE_MATRIX_FAST_TRANSPOSE_DEFINES_SVH
`define SPARSE_MATRIX_FAST_TRANSPOSE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define SMFT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define SMFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/smft_pkg.sv =====
package smft_pkg;

  // Capacity and dimension limits
  localparam int MAX_TERMS_STORED = 64;
  localparam int MAX_DIM          = 64;

  // Field widths
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int VAL_W  = 32;
  localparam int CFG_W  = 7;
  localparam int DROP_W = 6;

  // Derived index and count widths
  localparam int TERM_AW = (MAX_TERMS_STORED > 1) ? $clog2(MAX_TERMS_STORED) : 1;
  localparam int DIM_AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W   = $clog2(MAX_TERMS_STORED + 1);

  localparam logic [DROP_W-1:0] DROP_MAX = {DROP_W{1'b1}};

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [CFG_W-1:0] NUM_ROWS_RST = CFG_W'(64);
  localparam logic [CFG_W-1:0] NUM_COLS_RST = CFG_W'(64);

  typedef enum logic [0:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } reg_idx_t;

  // One held term
  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } term_t;

  // Controller to datapath
  typedef struct packed {
    logic idle;
    logic cnt_wr;
    logic pre_rd;
    logic pre_wr;
    logic sc_rd_term;
    logic sc_rd_start;
    logic sc_wr;
    logic em_rd_order;
    logic em_rd_term;
    logic em_load;
    logic clear;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic last_seen;
    logic store_empty;
    logic col_end;
    logic term_end;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/smft_if.sv =====
// Input transaction channel
interface smft_in_if;
  logic                               valid;
  logic                               ready;
  logic [smft_pkg::ROW_W-1:0]         term_row;
  logic [smft_pkg::COL_W-1:0]         term_col;
  logic signed [smft_pkg::VAL_W-1:0]  term_value;
  logic                               last;

  modport source(output valid, term_row, term_col, term_value, last, input ready);
  modport sink(input valid, term_row, term_col, term_value, last, output ready);
endinterface

// Result transaction channel
interface smft_out_if;
  logic                               valid;
  logic                               ready;
  logic [smft_pkg::COL_W-1:0]         out_row;
  logic [smft_pkg::ROW_W-1:0]         out_col;
  logic signed [smft_pkg::VAL_W-1:0]  out_value;
  logic                               out_last;
  logic [smft_pkg::DROP_W-1:0]        dropped_count;

  modport source(output valid, out_row, out_col, out_value, out_last, dropped_count,
                 input ready);
  modport sink(input valid, out_row, out_col, out_value, out_last, dropped_count,
               output ready);
endinterface

// ===== sv/sparse_matrix_fast_transpose.sv =====
// Channel   Dir  Contents                                          Transaction
// in_if     in   term_row, term_col, term_value, last              valid && ready
// out_if    out  out_row, out_col, out_value, out_last, dropped    valid && ready
// cfg_*     in   APB: row count at 0x0, column count at 0x4        psel && penable && pwrite
//
// Each term is loaded as a count read on accept, then a count write back.
// After the last term, if any is held: prefix sum over MAX_DIM columns (read, write),
// scatter per term (term, start read, write), emit per term (order, term read, load).
// Output stalls hold the emit sequencer; a waiting final result does not block input.
// Reset is synchronous and clears control state; no clearing pass is needed.
module sparse_matrix_fast_transpose (
  input  logic                         clk,
  input  logic                         rst_n,
  smft_in_if.sink                      in_if,
  smft_out_if.source                   out_if,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [smft_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [smft_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [smft_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  logic [smft_pkg::CFG_W-1:0] col_span;
  smft_pkg::cmd_t             cmd;
  smft_pkg::stat_t            stat;

  smft_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .col_span (col_span)
  );

  smft_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  smft_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .col_span (col_span),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ===== sv/smft_ram.sv =====
module smft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/smft_regs.sv =====
module smft_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [smft_pkg::APB_AW-1:0]  paddr,
  input  logic [smft_pkg::APB_DW-1:0]  pwdata,
  output logic [smft_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output logic [smft_pkg::CFG_W-1:0]   col_span
);

  logic [smft_pkg::CFG_W-1:0] num_rows_r;
  logic [smft_pkg::CFG_W-1:0] col_span_r;
  smft_pkg::reg_idx_t         idx;
  logic                       wr_en;

  assign idx    = smft_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= smft_pkg::NUM_ROWS_RST;
      col_span_r <= smft_pkg::NUM_COLS_RST;
    end else if (wr_en) begin
      unique case (idx)
        smft_pkg::REG_NUM_ROWS: num_rows_r <= pwdata[smft_pkg::CFG_W-1:0];
        smft_pkg::REG_NUM_COLS: col_span_r <= pwdata[smft_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      smft_pkg::REG_NUM_ROWS: prdata = smft_pkg::APB_DW'(num_rows_r);
      smft_pkg::REG_NUM_COLS: prdata = smft_pkg::APB_DW'(col_span_r);
      default:                prdata = '0;
    endcase
  end

  assign col_span = col_span_r;

endmodule

// ===== sv/smft_ctrl.sv =====
module smft_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  smft_pkg::stat_t stat,
  output smft_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT,
    S_PRE_RD,
    S_PRE_WR,
    S_SC_RD,
    S_SC_ST,
    S_SC_WR,
    S_EM_RD,
    S_EM_TM,
    S_EM_LD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (stat.in_valid) state_nxt = S_CNT;
      S_CNT: begin
        if (!stat.last_seen || stat.store_empty) state_nxt = S_IDLE;
        else                                     state_nxt = S_PRE_RD;
      end
      S_PRE_RD: state_nxt = S_PRE_WR;
      S_PRE_WR: state_nxt = stat.col_end ? S_SC_RD : S_PRE_RD;
      S_SC_RD:  state_nxt = S_SC_ST;
      S_SC_ST:  state_nxt = S_SC_WR;
      S_SC_WR:  state_nxt = stat.term_end ? S_EM_RD : S_SC_RD;
      S_EM_RD:  state_nxt = S_EM_TM;
      S_EM_TM:  state_nxt = S_EM_LD;
      S_EM_LD: begin
        if (stat.out_free) state_nxt = stat.term_end ? S_IDLE : S_EM_RD;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode commands
  always_comb begin
    cmd             = '0;
    cmd.idle        = (state_r == S_IDLE);
    cmd.cnt_wr      = (state_r == S_CNT);
    cmd.pre_rd      = (state_r == S_PRE_RD);
    cmd.pre_wr      = (state_r == S_PRE_WR);
    cmd.sc_rd_term  = (state_r == S_SC_RD);
    cmd.sc_rd_start = (state_r == S_SC_ST);
    cmd.sc_wr       = (state_r == S_SC_WR);
    cmd.em_rd_order = (state_r == S_EM_RD);
    cmd.em_rd_term  = (state_r == S_EM_TM);
    cmd.em_load     = (state_r == S_EM_LD) && stat.out_free;
    cmd.clear       = ((state_r == S_CNT) && stat.last_seen && stat.store_empty) ||
                      ((state_r == S_EM_LD) && stat.out_free && stat.term_end);
  end

endmodule

// ===== sv/smft_dpath.sv =====
module smft_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  smft_in_if.sink                     in_if,
  smft_out_if.source                  out_if,
  input  logic [smft_pkg::CFG_W-1:0]  col_span,
  input  smft_pkg::cmd_t              cmd,
  output smft_pkg::stat_t             stat
);

  logic                           in_hs;
  logic [smft_pkg::CFG_W-1:0]     limit;
  logic                           keep;

  logic [smft_pkg::COL_W-1:0]     col_r;
  logic                           keep_r;
  logic                           last_r;
  logic [smft_pkg::CNT_W-1:0]     loaded_r;
  logic [smft_pkg::DROP_W-1:0]    drop_r;
  logic [smft_pkg::DIM_AW-1:0]    c_r;
  logic [smft_pkg::CNT_W-1:0]     sum_r;
  logic [smft_pkg::TERM_AW-1:0]   i_r;

  // Column count store with per-entry valid bits
  logic [smft_pkg::MAX_DIM-1:0]   cvld_r;
  logic                           cnt_vld_r;
  logic                           cnt_re;
  logic [smft_pkg::DIM_AW-1:0]    cnt_raddr;
  logic [smft_pkg::CNT_W-1:0]     cnt_rdata;
  logic [smft_pkg::CNT_W-1:0]     cnt_eff;

  logic [$bits(smft_pkg::term_t)-1:0] term_rdata;
  smft_pkg::term_t                term_rd;
  smft_pkg::term_t                term_wr;
  logic [smft_pkg::TERM_AW-1:0]   term_raddr;

  logic [smft_pkg::CNT_W-1:0]     st_rdata;
  logic [smft_pkg::DIM_AW-1:0]    st_waddr;
  logic [smft_pkg::CNT_W-1:0]     st_wdata;

  logic [smft_pkg::TERM_AW-1:0]   ord_rdata;

  logic                           out_valid_r;
  logic [smft_pkg::COL_W-1:0]     out_row_r;
  logic [smft_pkg::ROW_W-1:0]     out_col_r;
  logic signed [smft_pkg::VAL_W-1:0] out_value_r;
  logic                           out_last_r;
  logic [smft_pkg::DROP_W-1:0]    out_drop_r;

  // Accept and classify the incoming term
  assign in_if.ready = cmd.idle;
  assign in_hs       = in_if.valid && in_if.ready;
  assign limit       = (col_span < smft_pkg::CFG_W'(smft_pkg::MAX_DIM)) ?
                       col_span : smft_pkg::CFG_W'(smft_pkg::MAX_DIM);
  assign keep        = (smft_pkg::CFG_W'(in_if.term_col) < limit) &&
                       (loaded_r < smft_pkg::CNT_W'(smft_pkg::MAX_TERMS_STORED));

  always_ff @(posedge clk) begin
    if (in_hs) begin
      col_r  <= in_if.term_col;
      keep_r <= keep;
      last_r <= in_if.last;
    end
  end

  // Track fill and drops for the current matrix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      drop_r   <= '0;
    end else if (cmd.clear) begin
      loaded_r <= '0;
      drop_r   <= '0;
    end else if (in_hs) begin
      if (keep) begin
        loaded_r <= loaded_r + smft_pkg::CNT_W'(1);
      end else if (drop_r != smft_pkg::DROP_MAX) begin
        drop_r <= drop_r + smft_pkg::DROP_W'(1);
      end
    end
  end

  // Term store
  assign term_wr    = '{row: in_if.term_row, col: in_if.term_col, value: in_if.term_value};
  assign term_raddr = cmd.em_rd_term ? ord_rdata : i_r;
  assign term_rd    = smft_pkg::term_t'(term_rdata);

  smft_ram #(.WIDTH($bits(smft_pkg::term_t)), .DEPTH(smft_pkg::MAX_TERMS_STORED)) u_term_ram (
    .clk   (clk),
    .we    (in_hs && keep),
    .waddr (loaded_r[smft_pkg::TERM_AW-1:0]),
    .wdata (term_wr),
    .re    (cmd.sc_rd_term || cmd.em_rd_term),
    .raddr (term_raddr),
    .rdata (term_rdata)
  );

  // Column counts: read on accept or during the prefix sweep, write back count plus one
  assign cnt_re    = in_hs || cmd.pre_rd;
  assign cnt_raddr = cmd.pre_rd ? c_r : in_if.term_col[smft_pkg::DIM_AW-1:0];
  assign cnt_eff   = cnt_vld_r ? cnt_rdata : '0;

  smft_ram #(.WIDTH(smft_pkg::CNT_W), .DEPTH(smft_pkg::MAX_DIM)) u_cnt_ram (
    .clk   (clk),
    .we    (cmd.cnt_wr && keep_r),
    .waddr (col_r[smft_pkg::DIM_AW-1:0]),
    .wdata (cnt_eff + smft_pkg::CNT_W'(1)),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r <= '0;
    end else if (cmd.clear) begin
      cvld_r <= '0;
    end else if (cmd.cnt_wr && keep_r) begin
      cvld_r[col_r[smft_pkg::DIM_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_re) begin
      cnt_vld_r <= cvld_r[cnt_raddr];
    end
  end

  // Start positions: written by the prefix sweep, bumped by the scatter
  assign st_waddr = cmd.pre_wr ? c_r : term_rd.col[smft_pkg::DIM_AW-1:0];
  assign st_wdata = cmd.pre_wr ? sum_r : st_rdata + smft_pkg::CNT_W'(1);

  smft_ram #(.WIDTH(smft_pkg::CNT_W), .DEPTH(smft_pkg::MAX_DIM)) u_start_ram (
    .clk   (clk),
    .we    (cmd.pre_wr || cmd.sc_wr),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (cmd.sc_rd_start),
    .raddr (term_rd.col[smft_pkg::DIM_AW-1:0]),
    .rdata (st_rdata)
  );

  // Emit order: slot p holds the store index of the p-th transposed term
  smft_ram #(.WIDTH(smft_pkg::TERM_AW), .DEPTH(smft_pkg::MAX_TERMS_STORED)) u_order_ram (
    .clk   (clk),
    .we    (cmd.sc_wr),
    .waddr (st_rdata[smft_pkg::TERM_AW-1:0]),
    .wdata (i_r),
    .re    (cmd.em_rd_order),
    .raddr (i_r),
    .rdata (ord_rdata)
  );

  // Sweep counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r   <= '0;
      sum_r <= '0;
    end else if (cmd.pre_wr) begin
      c_r   <= stat.col_end ? '0 : c_r + smft_pkg::DIM_AW'(1);
      sum_r <= stat.col_end ? '0 : sum_r + cnt_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
    end else if (cmd.clear) begin
      i_r <= '0;
    end else if (cmd.sc_wr || cmd.em_load) begin
      i_r <= stat.term_end ? '0 : i_r + smft_pkg::TERM_AW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.em_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.em_load) begin
      out_row_r   <= term_rd.col;
      out_col_r   <= term_rd.row;
      out_value_r <= term_rd.value;
      out_last_r  <= stat.term_end;
      out_drop_r  <= drop_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.out_row       = out_row_r;
  assign out_if.out_col       = out_col_r;
  assign out_if.out_value     = out_value_r;
  assign out_if.out_last      = out_last_r;
  assign out_if.dropped_count = out_drop_r;

  // Status back to the controller
  assign stat.in_valid    = in_if.valid;
  assign stat.last_seen   = last_r;
  assign stat.store_empty = (loaded_r == '0);
  assign stat.col_end     = (c_r == smft_pkg::DIM_AW'(smft_pkg::MAX_DIM - 1));
  assign stat.term_end    = ((smft_pkg::CNT_W'(i_r) + smft_pkg::CNT_W'(1)) == loaded_r);
  assign stat.out_free    = !out_valid_r || out_if.ready;

endmodule

// ===== sv/smft_checker.sv =====
`include "sparse_matrix_fast_transpose_defines.svh"

module smft_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [smft_pkg::COL_W-1:0]        out_row,
  input logic [smft_pkg::ROW_W-1:0]        out_col,
  input logic signed [smft_pkg::VAL_W-1:0] out_value,
  input logic                              out_last,
  input logic [smft_pkg::DROP_W-1:0]       dropped_count
);

  logic in_hs;
  logic out_hs;

  assign in_hs  = in_valid && in_ready;
  assign out_hs = out_valid && out_ready;

  // Stalled result holds
  `SMFT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_row) && $stable(out_col) && $stable(out_value) && $stable(out_last) && $stable(dropped_count), "stalled result changed")

  // A term load always includes the count write back before input is ready again
  `SMFT_ASSERT_NEXT(a_load_two_cycles, in_hs, !in_ready, "input ready right after a transaction")

  // No input while a matrix is still being emitted
  `SMFT_ASSERT_SAME(a_emit_blocks_input, out_hs && !out_last, !in_ready, "input ready during emit")

  // Drop count is the same for every result of a matrix
  `SMFT_ASSERT_NEXT(a_drop_steady, out_hs && !out_last, $stable(dropped_count), "drop count changed in a matrix")

endmodule

bind sparse_matrix_fast_transpose smft_checker u_smft_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_row       (out_if.out_row),
  .out_col       (out_if.out_col),
  .out_value     (out_if.out_value),
  .out_last      (out_if.out_last),
  .dropped_count (out_if.dropped_count)
);
